@@ rtl/core/tcvp_pkg.sv @@
// tcvp_pkg: shared types and constants for the cache victim policy block
// entry record kept in the state memory, request codes, register indexes
// no dependencies
package tcvp_pkg;

  typedef struct packed {
    logic        cached;
    logic [7:0]  open_cnt;
    logic [8:0]  idle;
    logic [31:0] size;
    logic [31:0] stamp;
  } entry_t;

  localparam logic [1:0] REQ_OPEN   = 2'd0;
  localparam logic [1:0] REQ_ACCESS = 2'd1;
  localparam logic [1:0] REQ_CLOSE  = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  localparam logic [1:0] CFG_CACHE_LIMIT = 2'd0;
  localparam logic [1:0] CFG_LARGE_LIMIT = 2'd1;
  localparam logic [1:0] CFG_IDLE_THR    = 2'd2;
  localparam logic [1:0] CFG_TOUCH       = 2'd3;

  localparam logic [31:0] CACHE_LIMIT_RST = 32'd16777216;
  localparam logic [31:0] LARGE_LIMIT_RST = 32'd1048576;
  localparam logic [8:0]  IDLE_THR_RST    = 9'd64;
  localparam logic [8:0]  TOUCH_RST       = 9'd256;

  localparam logic [5:0] MAX_EVICT = 6'd32;
  localparam logic [7:0] OPEN_MAX  = 8'd255;

endpackage

@@ rtl/core/tcvp_if.sv @@
// tcvp_if: valid/ready channel interfaces for requests, results and config
// depends on nothing
interface tcvp_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [4:0]  entry_index;
  logic [31:0] entry_size;
  logic        load_ok;
  modport source (output valid, req_type, entry_index, entry_size, load_ok, input ready);
  modport sink (input valid, req_type, entry_index, entry_size, load_ok, output ready);
endinterface

interface tcvp_res_if;
  logic        valid;
  logic        ready;
  logic [4:0]  evicted_index;
  logic        evicted_valid;
  logic        is_last;
  logic        now_cached;
  logic [31:0] cache_total;
  modport source (output valid, evicted_index, evicted_valid, is_last, now_cached,
                  cache_total, input ready);
  modport sink (input valid, evicted_index, evicted_valid, is_last, now_cached,
                cache_total, output ready);
endinterface

interface tcvp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/tiered_cache_victim_policy.sv @@
// tiered_cache_victim_policy: top level, request sequencer over the entry store
// depends on tcvp_pkg, tcvp_if, tcvp_store and tcvp_rank
//
// Requests arrive on in_if (open, access, close), one beat each; results leave
// on out_if. Every request ends with one status beat (is_last set); an open or
// access of an uncached entry whose size is below large_limit first gives one
// eviction beat per victim while cached bytes plus the new size reach
// cache_limit, at most 32 of them. The user must write registers on cfg_if only
// while idle; the block itself does not enforce this. The status beat of a request
// with no eviction is formed in the HEAD and then the STAT or FIN state and is
// registered for output. Each eviction costs one scan of the state memory (one entry
// a cycle through the single read port), and after the last eviction one more pass
// writes back the idle decrements. One request is in work at a time; the next is
// taken when the sequencer is back in idle, while the last status beat may still
// wait in the output register. Reset sets the registers to their reset values and
// clears the total, the stamp and all entry valid bits; no clearing pass is needed.
// A stalled receiver holds the output beat; the sequencer halts at its next beat.
module tiered_cache_victim_policy #(
  parameter int ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  tcvp_req_if.sink    in_if,
  tcvp_res_if.source  out_if,
  tcvp_cfg_if.sink    cfg_if
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [6:0]    ENT_L  = 7'(ENTRIES);
  localparam logic [CW-1:0] ENT_C  = CW'(ENTRIES);
  localparam logic [AW-1:0] LAST_A = AW'(ENTRIES - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HEAD   = 3'd1;
  localparam logic [2:0] S_STAT   = 3'd2;
  localparam logic [2:0] S_PASS   = 3'd3;
  localparam logic [2:0] S_DECIDE = 3'd4;
  localparam logic [2:0] S_EV     = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0]  state_r, state_nxt;
  logic [31:0] cache_limit_r, large_limit_r;
  logic [8:0]  idle_thr_r, touch_r;
  logic [31:0] total_r, total_nxt;
  logic [31:0] stamp_r, stamp_nxt;
  logic [1:0]  rt_r;
  logic [4:0]  idx_r;
  logic [31:0] size_r;
  logic        ok_r, range_r;
  tcvp_pkg::entry_t head_r, head_nxt;
  logic        stat_now_r, stat_now_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic        proc_v_r, proc_v_nxt;
  logic [AW-1:0] proc_a_r, proc_a_nxt;
  logic        scan_r, scan_nxt;
  logic        pend_v_r, pend_v_nxt;
  logic [AW-1:0] pend_a_r, pend_a_nxt;
  logic [5:0]  nev_r, nev_nxt;
  logic        out_v_r, out_v_nxt;
  logic [4:0]  o_idx_r, o_idx_nxt;
  logic        o_ev_r, o_ev_nxt, o_last_r, o_last_nxt, o_now_r, o_now_nxt;
  logic [31:0] o_tot_r, o_tot_nxt;

  logic        rd_en, wr_en, clear, out_free, need_ev, in_range, in_acc;
  logic [AW-1:0] rd_addr, wr_addr;
  tcvp_pkg::entry_t rd_data, wr_data, mod;
  logic        found;
  logic [AW-1:0] vic_idx;
  logic [31:0] vic_size;
  logic [32:0] sum;

  tcvp_store #(.ENTRIES(ENTRIES), .AW(AW)) u_store (
    .clk, .rst_n, .rd_en, .rd_addr, .wr_en, .wr_addr, .wr_data, .rd_data
  );

  tcvp_rank #(.AW(AW)) u_rank (
    .clk, .rst_n, .clear,
    .smp_v(proc_v_r && scan_r && (state_r == S_PASS)),
    .smp_idx(proc_a_r), .smp(mod),
    .idle_thr(idle_thr_r), .large_lim(large_limit_r),
    .found, .vic_idx, .vic_size
  );

  assign in_if.ready  = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign in_acc   = in_if.valid && in_if.ready;
  assign in_range = {2'b00, in_if.entry_index} < ENT_L;
  assign out_free = !out_v_r || out_if.ready;
  assign need_ev  = ({1'b0, total_r} + {1'b0, size_r}) >= {1'b0, cache_limit_r};
  assign sum      = {1'b0, total_r} + {1'b0, size_r};

  assign out_if.valid         = out_v_r;
  assign out_if.evicted_index = o_idx_r;
  assign out_if.evicted_valid = o_ev_r;
  assign out_if.is_last       = o_last_r;
  assign out_if.now_cached    = o_now_r;
  assign out_if.cache_total   = o_tot_r;

  always_comb begin
    mod = rd_data;
    if (pend_v_r) begin
      if (proc_a_r == pend_a_r) begin
        mod.cached = 1'b0;
      end else if (mod.cached && (mod.idle != '0)) begin
        mod.idle = mod.idle - 9'd1;
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    total_nxt    = total_r;
    stamp_nxt    = stamp_r;
    head_nxt     = head_r;
    stat_now_nxt = stat_now_r;
    cnt_nxt      = cnt_r;
    proc_v_nxt   = 1'b0;
    proc_a_nxt   = proc_a_r;
    scan_nxt     = scan_r;
    pend_v_nxt   = pend_v_r;
    pend_a_nxt   = pend_a_r;
    nev_nxt      = nev_r;
    out_v_nxt    = out_v_r && !out_if.ready;
    o_idx_nxt    = o_idx_r;
    o_ev_nxt     = o_ev_r;
    o_last_nxt   = o_last_r;
    o_now_nxt    = o_now_r;
    o_tot_nxt    = o_tot_r;
    rd_en        = 1'b0;
    rd_addr      = AW'(in_if.entry_index);
    wr_en        = 1'b0;
    wr_addr      = AW'(idx_r);
    wr_data      = head_r;
    clear        = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          rd_en     = in_range;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        head_nxt     = rd_data;
        stat_now_nxt = range_r && rd_data.cached;
        state_nxt    = S_STAT;
        wr_data      = rd_data;
        if (range_r) begin
          case (rt_r)
            tcvp_pkg::REQ_CLOSE: begin
              if (rd_data.open_cnt != '0) begin
                wr_data.open_cnt = rd_data.open_cnt - 8'd1;
              end
              wr_en = 1'b1;
            end
            tcvp_pkg::REQ_OPEN, tcvp_pkg::REQ_ACCESS: begin
              if (rd_data.cached) begin
                if (rt_r == tcvp_pkg::REQ_OPEN) begin
                  if (rd_data.open_cnt != tcvp_pkg::OPEN_MAX) begin
                    wr_data.open_cnt = rd_data.open_cnt + 8'd1;
                  end
                end else begin
                  wr_data.idle = touch_r;
                end
                wr_en = 1'b1;
              end else if ((size_r < large_limit_r) && need_ev) begin
                state_nxt = S_PASS;
                clear     = 1'b1;
                cnt_nxt   = '0;
                scan_nxt  = 1'b1;
                nev_nxt   = '0;
              end else begin
                state_nxt = S_FIN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_STAT: begin
        if (out_free) begin
          out_v_nxt  = 1'b1;
          o_idx_nxt  = '0;
          o_ev_nxt   = 1'b0;
          o_last_nxt = 1'b1;
          o_now_nxt  = stat_now_r;
          o_tot_nxt  = total_r;
          state_nxt  = S_IDLE;
        end
      end
      S_PASS: begin
        if (cnt_r != ENT_C) begin
          rd_en      = 1'b1;
          rd_addr    = cnt_r[AW-1:0];
          cnt_nxt    = cnt_r + 1'b1;
          proc_v_nxt = 1'b1;
          proc_a_nxt = cnt_r[AW-1:0];
        end
        if (proc_v_r) begin
          wr_en   = 1'b1;
          wr_addr = proc_a_r;
          wr_data = mod;
          if (proc_a_r == LAST_A) begin
            pend_v_nxt = 1'b0;
            state_nxt  = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (scan_r && found) begin
          total_nxt  = (total_r >= vic_size) ? total_r - vic_size : '0;
          pend_v_nxt = 1'b1;
          pend_a_nxt = vic_idx;
          nev_nxt    = nev_r + 6'd1;
          state_nxt  = S_EV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_EV: begin
        if (out_free) begin
          out_v_nxt  = 1'b1;
          o_idx_nxt  = 5'(pend_a_r);
          o_ev_nxt   = 1'b1;
          o_last_nxt = 1'b0;
          o_now_nxt  = 1'b0;
          o_tot_nxt  = total_r;
          state_nxt  = S_PASS;
          clear      = 1'b1;
          cnt_nxt    = '0;
          scan_nxt   = need_ev && (nev_r < tcvp_pkg::MAX_EVICT);
        end
      end
      S_FIN: begin
        if (out_free) begin
          wr_en   = 1'b1;
          wr_data = head_r;
          if (ok_r) begin
            wr_data.cached = 1'b1;
            wr_data.size   = size_r;
            wr_data.stamp  = stamp_r;
            total_nxt      = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            stamp_nxt      = stamp_r + 32'd1;
          end
          if ((rt_r == tcvp_pkg::REQ_OPEN) && ok_r &&
              (head_r.open_cnt != tcvp_pkg::OPEN_MAX)) begin
            wr_data.open_cnt = head_r.open_cnt + 8'd1;
          end
          if (rt_r == tcvp_pkg::REQ_ACCESS) begin
            wr_data.idle = touch_r;
          end
          out_v_nxt  = 1'b1;
          o_idx_nxt  = '0;
          o_ev_nxt   = 1'b0;
          o_last_nxt = 1'b1;
          o_now_nxt  = ok_r;
          o_tot_nxt  = total_nxt;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      total_r       <= '0;
      stamp_r       <= '0;
      proc_v_r      <= 1'b0;
      pend_v_r      <= 1'b0;
      out_v_r       <= 1'b0;
      cnt_r         <= '0;
      scan_r        <= 1'b0;
      nev_r         <= '0;
      cache_limit_r <= tcvp_pkg::CACHE_LIMIT_RST;
      large_limit_r <= tcvp_pkg::LARGE_LIMIT_RST;
      idle_thr_r    <= tcvp_pkg::IDLE_THR_RST;
      touch_r       <= tcvp_pkg::TOUCH_RST;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      stamp_r  <= stamp_nxt;
      proc_v_r <= proc_v_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      cnt_r    <= cnt_nxt;
      scan_r   <= scan_nxt;
      nev_r    <= nev_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_if.index)
          tcvp_pkg::CFG_CACHE_LIMIT: cache_limit_r <= cfg_if.data;
          tcvp_pkg::CFG_LARGE_LIMIT: large_limit_r <= cfg_if.data;
          tcvp_pkg::CFG_IDLE_THR:    idle_thr_r    <= cfg_if.data[8:0];
          tcvp_pkg::CFG_TOUCH:       touch_r       <= cfg_if.data[8:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    head_r     <= head_nxt;
    stat_now_r <= stat_now_nxt;
    proc_a_r   <= proc_a_nxt;
    pend_a_r   <= pend_a_nxt;
    o_idx_r    <= o_idx_nxt;
    o_ev_r     <= o_ev_nxt;
    o_last_r   <= o_last_nxt;
    o_now_r    <= o_now_nxt;
    o_tot_r    <= o_tot_nxt;
    if (in_acc) begin
      rt_r    <= in_if.req_type;
      idx_r   <= in_if.entry_index;
      size_r  <= in_if.entry_size;
      ok_r    <= in_if.load_ok;
      range_r <= in_range;
    end
  end

endmodule

@@ rtl/core/tcvp_store.sv @@
// tcvp_store: per-entry state memory, one write and one registered read port
// entries never written read back as uncached with zero counts
// depends on tcvp_pkg
module tcvp_store #(
  parameter int ENTRIES = 32,
  parameter int AW      = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  tcvp_pkg::entry_t     wr_data,
  output tcvp_pkg::entry_t     rd_data
);

  tcvp_pkg::entry_t mem [ENTRIES];
  tcvp_pkg::entry_t q_r;
  logic [ENTRIES-1:0] vld_r;
  logic q_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        q_vld_r <= vld_r[rd_addr];
      end
    end
  end

  always_comb begin
    rd_data = q_r;
    if (!q_vld_r) begin
      rd_data.cached   = 1'b0;
      rd_data.open_cnt = '0;
      rd_data.idle     = '0;
    end
  end

endmodule

@@ rtl/core/tcvp_rank.sv @@
// tcvp_rank: four tier trackers fed one entry a cycle during a scan
// gives the victim of the first tier holding a candidate
// depends on tcvp_pkg
module tcvp_rank #(
  parameter int AW = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic              smp_v,
  input  logic [AW-1:0]     smp_idx,
  input  tcvp_pkg::entry_t  smp,
  input  logic [8:0]        idle_thr,
  input  logic [31:0]       large_lim,
  output logic              found,
  output logic [AW-1:0]     vic_idx,
  output logic [31:0]       vic_size
);

  logic        v_r     [4];
  logic [AW-1:0] idx_r [4];
  logic [8:0]  idle_r  [4];
  logic [31:0] size_r  [4];
  logic [31:0] stamp_r [4];
  logic        elig    [4];
  logic        win     [4];

  always_comb begin
    elig[0] = smp.cached && (smp.idle < idle_thr);
    elig[1] = smp.cached && (smp.open_cnt == '0);
    elig[2] = smp.cached && (smp.size < large_lim);
    elig[3] = smp.cached;
    for (int t = 0; t < 4; t++) begin
      if (!v_r[t]) begin
        win[t] = 1'b1;
      end else if (t < 2) begin
        win[t] = (smp.idle < idle_r[t]) ||
                 ((smp.idle == idle_r[t]) && (smp.stamp < stamp_r[t]));
      end else begin
        win[t] = (smp.size > size_r[t]) ||
                 ((smp.size == size_r[t]) && (smp.stamp < stamp_r[t]));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t < 4; t++) begin
      if (!rst_n || clear) begin
        v_r[t] <= 1'b0;
      end else if (smp_v && elig[t] && win[t]) begin
        v_r[t]     <= 1'b1;
        idx_r[t]   <= smp_idx;
        idle_r[t]  <= smp.idle;
        size_r[t]  <= smp.size;
        stamp_r[t] <= smp.stamp;
      end
    end
  end

  always_comb begin
    found    = 1'b0;
    vic_idx  = idx_r[3];
    vic_size = size_r[3];
    for (int t = 3; t >= 0; t--) begin
      if (v_r[t]) begin
        found    = 1'b1;
        vic_idx  = idx_r[t];
        vic_size = size_r[t];
      end
    end
  end

endmodule

@@ rtl/core/tcvp_check.sv @@
// tcvp_check: port-level assertions for the cache victim policy block
// bound to tiered_cache_victim_policy, whose tcvp_if ports it reads
module tcvp_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        evicted_valid,
  input logic        is_last,
  input logic        now_cached,
  input logic [31:0] cache_total
);

  // a held beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a held beat keeps its total
  a_tot_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(cache_total))
    else $error("result beat total changed while stalled");

  // each beat is either an eviction or the closing status
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (evicted_valid != is_last))
    else $error("result beat kind inconsistent");

  // eviction beats never report the named entry as cached
  a_ev_now: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && evicted_valid |-> !now_cached)
    else $error("eviction beat with now_cached set");

  // after a request is taken, the block is not ready in the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken back to back");

endmodule

bind tiered_cache_victim_policy tcvp_check u_tcvp_check (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_if.valid),
  .in_ready      (in_if.ready),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .evicted_valid (out_if.evicted_valid),
  .is_last       (out_if.is_last),
  .now_cached    (out_if.now_cached),
  .cache_total   (out_if.cache_total)
);

@@ tb/sv/tiered_cache_victim_policy_tb.sv @@
// tiered_cache_victim_policy_tb: self-checking bench for the cache victim policy block
// directed table then random requests, checked beat by beat against a local predictor
// depends on tcvp_pkg, tcvp_if and the tiered_cache_victim_policy rtl
module tiered_cache_victim_policy_tb;

  localparam int NSLOT = 32;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic [4:0]  evicted_index;
    logic        evicted_valid;
    logic        is_last;
    logic        now_cached;
    logic [31:0] cache_total;
  } beat_t;

  typedef struct {
    logic [1:0]  req_type;
    logic [4:0]  entry_index;
    logic [31:0] entry_size;
    logic        load_ok;
    bit          typed;
    logic        now_cached;
    logic [31:0] cache_total;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tcvp_req_if in_if ();
  tcvp_res_if out_if ();
  tcvp_cfg_if cfg_if ();

  tiered_cache_victim_policy #(.ENTRIES(NSLOT)) DUT (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source), .cfg_if(cfg_if.sink)
  );

  always #1 clk = ~clk;

  // predictor copy of the block state
  logic [31:0] m_cache_limit, m_large_limit;
  logic [8:0]  m_idle_thr, m_touch;
  logic        m_cached [NSLOT];
  logic [7:0]  m_open [NSLOT];
  logic [8:0]  m_idle [NSLOT];
  logic [31:0] m_size [NSLOT];
  logic [31:0] m_stamp [NSLOT];
  logic [31:0] m_stamp_next, m_total;

  beat_t pending_beats[$];
  beat_t last_status;
  int    errors = 0;
  int    mode = 0;
  bit    hold_on = 1'b0;
  int    quiet_cycles = 0;

  task automatic report_mismatch(input string what, input beat_t got, input beat_t want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic beat_t out_if_beat();
    return '{out_if.evicted_index, out_if.evicted_valid, out_if.is_last,
             out_if.now_cached, out_if.cache_total};
  endfunction

  function automatic void reset_predictor();
    m_cache_limit = tcvp_pkg::CACHE_LIMIT_RST;
    m_large_limit = tcvp_pkg::LARGE_LIMIT_RST;
    m_idle_thr = tcvp_pkg::IDLE_THR_RST;
    m_touch = tcvp_pkg::TOUCH_RST;
    for (int i = 0; i < NSLOT; i++) begin
      m_cached[i] = 1'b0;
      m_open[i] = '0;
      m_idle[i] = '0;
      m_size[i] = '0;
      m_stamp[i] = '0;
    end
    m_stamp_next = '0;
    m_total = '0;
  endfunction

  function automatic int choose_victim();
    int best;
    bit elig;
    bit take;
    for (int tier = 1; tier <= 4; tier++) begin
      best = -1;
      for (int i = 0; i < NSLOT; i++) begin
        if (!m_cached[i]) continue;
        case (tier)
          1: elig = m_idle[i] < m_idle_thr;
          2: elig = m_open[i] == 8'd0;
          3: elig = m_size[i] < m_large_limit;
          default: elig = 1'b1;
        endcase
        if (!elig) continue;
        if (best < 0) take = 1'b1;
        else if (tier <= 2 && m_idle[i] != m_idle[best]) take = m_idle[i] < m_idle[best];
        else if (tier > 2 && m_size[i] != m_size[best]) take = m_size[i] > m_size[best];
        else take = m_stamp[i] < m_stamp[best];
        if (take) best = i;
      end
      if (best >= 0) return best;
    end
    return -1;
  endfunction

  function automatic void predict_request(input logic [1:0] rt, input logic [4:0] idx,
                                          input logic [31:0] sz, input logic ok);
    int n;
    int v;
    logic [32:0] sum;
    beat_t b;
    n = 0;
    if (rt == tcvp_pkg::REQ_OPEN || rt == tcvp_pkg::REQ_ACCESS) begin
      if (!m_cached[idx]) begin
        if (sz < m_large_limit) begin
          while ({1'b0, m_total} + {1'b0, sz} >= {1'b0, m_cache_limit} &&
                 n < tcvp_pkg::MAX_EVICT) begin
            v = choose_victim();
            if (v < 0) break;
            m_cached[v] = 1'b0;
            m_total = (m_total >= m_size[v]) ? m_total - m_size[v] : '0;
            for (int i = 0; i < NSLOT; i++)
              if (m_cached[i] && m_idle[i] > 9'd0) m_idle[i] = m_idle[i] - 9'd1;
            b = '{evicted_index: v[4:0], evicted_valid: 1'b1, is_last: 1'b0,
                  now_cached: 1'b0, cache_total: m_total};
            pending_beats.push_back(b);
            n++;
          end
        end
        if (ok) begin
          sum = {1'b0, m_total} + {1'b0, sz};
          m_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          m_cached[idx] = 1'b1;
          m_size[idx] = sz;
          m_stamp[idx] = m_stamp_next;
          m_stamp_next = m_stamp_next + 32'd1;
        end
      end
      if (rt == tcvp_pkg::REQ_OPEN && m_cached[idx] && m_open[idx] < tcvp_pkg::OPEN_MAX)
        m_open[idx] = m_open[idx] + 8'd1;
      if (rt == tcvp_pkg::REQ_ACCESS) m_idle[idx] = m_touch;
    end else if (rt == tcvp_pkg::REQ_CLOSE) begin
      if (m_open[idx] > 8'd0) m_open[idx] = m_open[idx] - 8'd1;
    end
    b = '{evicted_index: 5'd0, evicted_valid: 1'b0, is_last: 1'b1,
          now_cached: m_cached[idx], cache_total: m_total};
    pending_beats.push_back(b);
    last_status = b;
  endfunction

  task automatic write_reg(input logic [1:0] index, input logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (index)
      tcvp_pkg::CFG_CACHE_LIMIT: m_cache_limit = data;
      tcvp_pkg::CFG_LARGE_LIMIT: m_large_limit = data;
      tcvp_pkg::CFG_IDLE_THR:    m_idle_thr = data[8:0];
      tcvp_pkg::CFG_TOUCH:       m_touch = data[8:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_regs(input logic [31:0] cl, input logic [31:0] ll,
                          input logic [8:0] thr, input logic [8:0] tv);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    write_reg(tcvp_pkg::CFG_CACHE_LIMIT, cl);
    write_reg(tcvp_pkg::CFG_LARGE_LIMIT, ll);
    write_reg(tcvp_pkg::CFG_IDLE_THR, {23'd0, thr});
    write_reg(tcvp_pkg::CFG_TOUCH, {23'd0, tv});
  endtask

  task automatic send_request(input logic [1:0] rt, input logic [4:0] idx,
                              input logic [31:0] sz, input logic ok);
    int gap_pct;
    gap_pct = (mode == 1) ? 53 : (mode == 3) ? 27 : 0;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.req_type <= rt;
    in_if.entry_index <= idx;
    in_if.entry_size <= sz;
    in_if.load_ok <= ok;
    do @(posedge clk); while (!in_if.ready);
    predict_request(rt, idx, sz, ok);
  endtask

  task automatic random_phase(input int count, input logic [31:0] size_max);
    logic [1:0]  rt;
    logic [31:0] sz;
    int pick;
    for (int k = 0; k < count; k++) begin
      if (k % 30 == 0) mode = $urandom_range(3);
      pick = $urandom_range(99);
      rt = (pick < 45) ? tcvp_pkg::REQ_OPEN : (pick < 78) ? tcvp_pkg::REQ_ACCESS :
           (pick < 96) ? tcvp_pkg::REQ_CLOSE : tcvp_pkg::REQ_NONE;
      sz = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(size_max);
      send_request(rt, 5'($urandom_range(31)), sz, $urandom_range(99) < 85);
    end
    in_if.valid <= 1'b0;
  endtask

  row_t rows[] = '{
    '{tcvp_pkg::REQ_OPEN,   5'd0,  32'd100,        1'b1, 1'b1, 1'b1, 32'd100},
    '{tcvp_pkg::REQ_CLOSE,  5'd0,  32'd0,          1'b0, 1'b1, 1'b1, 32'd100},
    '{tcvp_pkg::REQ_NONE,   5'd5,  32'd0,          1'b1, 1'b1, 1'b0, 32'd100},
    '{tcvp_pkg::REQ_CLOSE,  5'd7,  32'd0,          1'b0, 1'b1, 1'b0, 32'd100},
    '{tcvp_pkg::REQ_ACCESS, 5'd31, 32'hFFFF_FFFF,  1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{tcvp_pkg::REQ_OPEN,   5'd0,  32'd5,          1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{tcvp_pkg::REQ_OPEN,   5'd2,  32'd5,          1'b0, 1'b0, 1'b0, 32'd0},
    '{tcvp_pkg::REQ_ACCESS, 5'd3,  32'd0,          1'b1, 1'b0, 1'b0, 32'd0},
    '{tcvp_pkg::REQ_OPEN,   5'd4,  32'd1048575,    1'b1, 1'b0, 1'b0, 32'd0},
    '{tcvp_pkg::REQ_OPEN,   5'd5,  32'd16777215,   1'b1, 1'b0, 1'b0, 32'd0},
    '{tcvp_pkg::REQ_OPEN,   5'd6,  32'd1048576,    1'b1, 1'b0, 1'b0, 32'd0},
    '{tcvp_pkg::REQ_ACCESS, 5'd7,  32'd200000,     1'b1, 1'b0, 1'b0, 32'd0},
    '{tcvp_pkg::REQ_OPEN,   5'd8,  32'd8000000,    1'b1, 1'b0, 1'b0, 32'd0},
    '{tcvp_pkg::REQ_CLOSE,  5'd8,  32'd0,          1'b1, 1'b0, 1'b0, 32'd0},
    '{tcvp_pkg::REQ_OPEN,   5'd9,  32'd9000000,    1'b0, 1'b0, 1'b0, 32'd0},
    '{tcvp_pkg::REQ_OPEN,   5'd10, 32'd9000000,    1'b1, 1'b0, 1'b0, 32'd0},
    '{tcvp_pkg::REQ_ACCESS, 5'd11, 32'h0AAA_AAAA,  1'b1, 1'b0, 1'b0, 32'd0},
    '{tcvp_pkg::REQ_OPEN,   5'd21, 32'h0055_5555,  1'b1, 1'b0, 1'b0, 32'd0},
    '{tcvp_pkg::REQ_NONE,   5'd31, 32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, 32'd0}
  };

  // receiver side and beat checking
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (pending_beats.size() == 0) begin
          report_mismatch("unexpected beat", out_if_beat(), '0);
        end else begin
          if (out_if_beat() !== pending_beats[0])
            report_mismatch("result beat", out_if_beat(), pending_beats[0]);
          void'(pending_beats.pop_front());
        end
      end
      if (hold_on) begin
        out_if.ready <= 1'b0;
      end else if (mode == 2) begin
        out_if.ready <= $urandom_range(99) >= 53;
      end else if (mode == 3) begin
        out_if.ready <= $urandom_range(99) >= 27;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.req_type = tcvp_pkg::REQ_NONE;
    in_if.entry_index = '0;
    in_if.entry_size = '0;
    in_if.load_ok = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = tcvp_pkg::CFG_CACHE_LIMIT;
    cfg_if.data = '0;
    reset_predictor();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows, checked with reset register values
    foreach (rows[r]) begin
      send_request(rows[r].req_type, rows[r].entry_index, rows[r].entry_size, rows[r].load_ok);
      if (rows[r].typed && (last_status.now_cached !== rows[r].now_cached ||
                            last_status.cache_total !== rows[r].cache_total))
        report_mismatch("table row", last_status,
                        '{5'd0, 1'b0, 1'b1, rows[r].now_cached, rows[r].cache_total});
    end
    in_if.valid <= 1'b0;

    set_regs(32'd2000, 32'd600, 9'd64, 9'd256);
    random_phase(60, 32'd700);
    // long receiver hold while requests keep coming
    mode = 0;
    fork
      begin
        hold_on = 1'b1;
        repeat (400) @(posedge clk);
        hold_on = 1'b0;
      end
      begin
        for (int k = 0; k < 20; k++)
          send_request(tcvp_pkg::REQ_OPEN, 5'($urandom_range(31)), $urandom_range(700), 1'b1);
      end
    join
    in_if.valid <= 1'b0;
    random_phase(60, 32'd700);
    set_regs(32'd1, 32'hFFFF_FFFF, 9'd511, 9'd0);
    random_phase(80, 32'd50);
    set_regs(32'hFFFF_FFFF, 32'd1, 9'd0, 9'd511);
    random_phase(80, 32'h4000_0000);
    set_regs(32'd5000, 32'd1500, 9'd200, 9'd100);
    random_phase(140, 32'd1800);

    while (pending_beats.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/tcvp_pkg.sv
rtl/core/tcvp_if.sv
rtl/core/tcvp_store.sv
rtl/core/tcvp_rank.sv
rtl/core/tiered_cache_victim_policy.sv
rtl/core/tcvp_check.sv
tb/sv/tiered_cache_victim_policy_tb.sv
